@@ rtl/core/delta_run_length_encoder_macros.svh @@
// assertion macros for the delta run-length encoder
// used by dre_encode and dre_out_queue; no other dependencies
`ifndef DELTA_RUN_LENGTH_ENCODER_MACROS_SVH
`define DELTA_RUN_LENGTH_ENCODER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication under reset
`define DRE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dre assertion failed");
// next-cycle implication under reset
`define DRE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dre assertion failed");
`else
`define DRE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DRE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/dre_pkg.sv @@
// shared types and constants for the delta run-length encoder
// no dependencies
`timescale 1ns / 1ps

package dre_pkg;

    // width of the run length counter, capped at 32 bits of count
    localparam int COUNT_BITS = 32;
    localparam int RUN_BITS   = (COUNT_BITS < 32) ? COUNT_BITS : 32;

    // token queue geometry
    localparam int DEPTH     = 4;
    localparam int PTR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_APPEND     = 2'h0,
        OP_CHECKPOINT = 2'h1,
        OP_FLUSH      = 2'h2,
        OP_IGNORE     = 2'h3
    } op_t;

    typedef enum logic [1:0] {
        TAG_POS = 2'h0,
        TAG_NEG = 2'h1,
        TAG_ABS = 2'h2,
        TAG_RUN = 2'h3
    } tag_t;

    typedef struct packed {
        tag_t               tag;
        logic [31:0]        payload;
        logic signed [31:0] run_step;
        logic               last;
    } token_t;

    // tokens produced by one accepted item, packed from tok0
    typedef struct packed {
        logic [1:0] cnt;
        token_t     tok0;
        token_t     tok1;
    } push_t;

endpackage

@@ rtl/core/delta_run_length_encoder.sv @@
// delta run-length encoder top level: one id or command in, tokens out
// the tokens of an item enter the registered token queue on its transfer
// throughput: one item per cycle while in_stall is low; a checkpoint that closes a run gives
// two tokens at once; in_stall is high while the four-entry token queue holds three or four
// reset: rst_n clears the previous id, run difference, run length and the token queue
`timescale 1ns / 1ps

module delta_run_length_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [31:0]        value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         tag,
    output logic [31:0]        payload,
    output logic signed [31:0] run_step,
    output logic               last
);
    import dre_pkg::*;

    logic   accept;
    logic   full;
    push_t  push;
    token_t head;

    // input transfer
    assign in_stall = full;
    assign accept   = in_valid && !full;

    dre_encode u_encode (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .op     (op_t'(operation)),
        .value  (value),
        .push   (push)
    );

    dre_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // output fields
    assign tag      = head.tag;
    assign payload  = head.payload;
    assign run_step = head.run_step;
    assign last     = head.last;

endmodule

@@ rtl/core/dre_encode.sv @@
// run state registers and token generation for one accepted item
// depends on dre_pkg and delta_run_length_encoder_macros.svh
`timescale 1ns / 1ps
`include "delta_run_length_encoder_macros.svh"

module dre_encode (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  dre_pkg::op_t   op,
    input  logic [31:0]    value,
    output dre_pkg::push_t push
);
    import dre_pkg::*;

    logic [31:0]         prev_reg, prev_next;
    logic [31:0]         diff_reg, diff_next;
    logic [RUN_BITS-1:0] len_reg, len_next;

    logic        neg;
    logic [31:0] mag;
    logic [31:0] new_diff;
    logic        close_vld;
    token_t      close_tok;
    token_t      abs_tok;

    // token that closes the pending run
    always_comb
    begin
        neg       = diff_reg[31];
        mag       = neg ? (32'd0 - diff_reg) : diff_reg;
        close_vld = (len_reg != '0);
        close_tok.tag      = TAG_RUN;
        close_tok.payload  = 32'(len_reg);
        close_tok.run_step = diff_reg;
        close_tok.last     = 1'b1;
        if (len_reg == RUN_BITS'(1))
        begin
            close_tok.run_step = '0;
            if (prev_reg > mag)
            begin
                if (neg)
                begin
                    close_tok.tag = TAG_NEG;
                end
                else
                begin
                    close_tok.tag = TAG_POS;
                end
                close_tok.payload = mag;
            end
            else
            begin
                close_tok.tag     = TAG_ABS;
                close_tok.payload = prev_reg;
            end
        end
    end

    // next state and tokens for the item on the input
    always_comb
    begin
        new_diff         = value - prev_reg;
        abs_tok.tag      = TAG_ABS;
        abs_tok.payload  = value;
        abs_tok.run_step = '0;
        abs_tok.last     = 1'b1;
        prev_next = prev_reg;
        diff_next = diff_reg;
        len_next  = len_reg;
        push.cnt  = 2'd0;
        push.tok0 = close_tok;
        push.tok1 = abs_tok;
        unique case (op)
            OP_APPEND:
            begin
                prev_next = value;
                if (new_diff == diff_reg)
                begin
                    if (len_reg == '1)
                    begin
                        // saturated run goes out whole, a new run starts
                        push.cnt           = 2'd1;
                        push.tok0.tag      = TAG_RUN;
                        push.tok0.payload  = 32'(len_reg);
                        push.tok0.run_step = diff_reg;
                        len_next           = RUN_BITS'(1);
                    end
                    else
                    begin
                        len_next = len_reg + RUN_BITS'(1);
                    end
                end
                else
                begin
                    push.cnt  = close_vld ? 2'd1 : 2'd0;
                    len_next  = RUN_BITS'(1);
                    diff_next = new_diff;
                end
            end
            OP_CHECKPOINT:
            begin
                prev_next = value;
                diff_next = '0;
                len_next  = '0;
                if (close_vld)
                begin
                    push.cnt       = 2'd2;
                    push.tok0.last = 1'b0;
                end
                else
                begin
                    push.cnt  = 2'd1;
                    push.tok0 = abs_tok;
                end
            end
            OP_FLUSH:
            begin
                diff_next = '0;
                len_next  = '0;
                push.cnt  = close_vld ? 2'd1 : 2'd0;
            end
            OP_IGNORE:
            begin
                push.cnt = 2'd0;
            end
            default:
            begin
                push.cnt = 2'd0;
            end
        endcase
        if (!accept)
        begin
            push.cnt = 2'd0;
        end
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            diff_reg <= '0;
            len_reg  <= '0;
        end
        else if (accept)
        begin
            prev_reg <= prev_next;
            diff_reg <= diff_next;
            len_reg  <= len_next;
        end
    end

    `DRE_ASSERT_IMP(a_two_only_ckpt, clk, rst_n, push.cnt == 2'd2, accept && op == OP_CHECKPOINT)
    `DRE_ASSERT_NXT(a_ckpt_state, clk, rst_n, accept && op == OP_CHECKPOINT, len_reg == '0 && prev_reg == $past(value))
    `DRE_ASSERT_IMP(a_no_tok_idle, clk, rst_n, !accept, push.cnt == 2'd0)

endmodule

@@ rtl/core/dre_out_queue.sv @@
// four-entry token queue between the encoder and the output channel
// depends on dre_pkg and delta_run_length_encoder_macros.svh
`timescale 1ns / 1ps
`include "delta_run_length_encoder_macros.svh"

module dre_out_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  dre_pkg::push_t  push,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output dre_pkg::token_t head
);
    import dre_pkg::*;

    token_t              entries [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                pop;

    // room for two tokens is required before an item is taken
    assign full      = (count_reg > CNT_BITS'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push.cnt) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entries[wr_ptr_reg] <= push.tok0;
        end
        if (push.cnt == 2'd2)
        begin
            entries[wr_ptr_reg + PTR_BITS'(1)] <= push.tok1;
        end
    end

    `DRE_ASSERT_IMP(a_no_overflow, clk, rst_n, push.cnt != 2'd0, count_reg <= CNT_BITS'(DEPTH) - CNT_BITS'(push.cnt))
    `DRE_ASSERT_NXT(a_pop_count, clk, rst_n, pop && push.cnt == 2'd0, count_reg == $past(count_reg) - CNT_BITS'(1))
    `DRE_ASSERT_IMP(a_ptr_gap, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

@@ tb/sv/tb.sv @@
// testbench for delta_run_length_encoder: directed and random id streams with token checks
// depends on dre_pkg for the operation and tag encodings and the run counter width
`timescale 1ns / 1ps

module tb;
    import dre_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam logic [63:0] COUNT_CAP = (COUNT_BITS >= 32) ? 64'hFFFF_FFFF
                                        : ((64'd1 << COUNT_BITS) - 64'd1);

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         operation = OP_APPEND;
    logic [31:0]        value = 32'h0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         tag;
    logic [31:0]        payload;
    logic signed [31:0] run_step;
    logic               last;

    // encoder state as the predictor sees it
    logic [31:0] enc_prev;
    logic [31:0] enc_step;
    logic [63:0] enc_count;

    // tokens of the item in flight and tokens still owed by the block
    token_t item_tokens [2];
    int     item_count;
    token_t owed_tokens [$];

    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;

    delta_run_length_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tag       (tag),
        .payload   (payload),
        .run_step  (run_step),
        .last      (last)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #3_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic token_t make_token(input tag_t tg, input logic [31:0] pl,
                                          input logic [31:0] st);
        token_t t;
        t.tag      = tg;
        t.payload  = pl;
        t.run_step = st;
        t.last     = 1'b0;
        return t;
    endfunction

    // close the pending run into zero or one token
    task automatic retire_run();
        logic        neg;
        logic [31:0] mag;
        neg = enc_step[31];
        mag = neg ? (32'h0 - enc_step) : enc_step;
        if (enc_count == 64'd1)
        begin
            if (enc_prev > mag)
            begin
                if (neg)
                    item_tokens[item_count] = make_token(TAG_NEG, mag, 32'h0);
                else
                    item_tokens[item_count] = make_token(TAG_POS, mag, 32'h0);
            end
            else
                item_tokens[item_count] = make_token(TAG_ABS, enc_prev, 32'h0);
            item_count++;
        end
        else if (enc_count > 64'd1)
        begin
            item_tokens[item_count] = make_token(TAG_RUN, enc_count[31:0], enc_step);
            item_count++;
        end
        enc_count = 64'd0;
        enc_step  = 32'h0;
    endtask

    // work out the tokens one accepted item causes and queue them
    task automatic predict_tokens(input op_t op, input logic [31:0] v);
        logic [31:0] d;
        item_count = 0;
        case (op)
            OP_APPEND:
            begin
                d = v - enc_prev;
                if (d == enc_step)
                begin
                    // a full counter goes out and a fresh run of one follows
                    if (enc_count >= COUNT_CAP)
                    begin
                        item_tokens[item_count] = make_token(TAG_RUN, enc_count[31:0],
                                                             enc_step);
                        item_count++;
                        enc_count = 64'd1;
                    end
                    else
                        enc_count = enc_count + 64'd1;
                end
                else
                begin
                    retire_run();
                    enc_count = 64'd1;
                    enc_step  = d;
                end
                enc_prev = v;
            end
            OP_CHECKPOINT:
            begin
                retire_run();
                enc_prev = v;
                item_tokens[item_count] = make_token(TAG_ABS, v, 32'h0);
                item_count++;
            end
            OP_FLUSH:
                retire_run();
            default:
                ;
        endcase
        if (item_count > 0)
            item_tokens[item_count - 1].last = 1'b1;
        for (int i = 0; i < item_count; i++)
            owed_tokens.push_back(item_tokens[i]);
    endtask

    // offer one item, hold it until the transfer, then predict
    task automatic send_item(input op_t op, input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_tokens(op, v);
    endtask

    // drop valid and wait until every owed token has arrived
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (owed_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // token checker
    always @(posedge clk)
    begin : token_check
        token_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_tokens.size() == 0)
            begin
                $error("unexpected token: tag %0d payload %0h run_step %0d last %0d",
                       tag, payload, run_step, last);
                mismatches++;
            end
            else
            begin
                want = owed_tokens.pop_front();
                if (tag !== want.tag)
                begin
                    $error("tag: expected %0d, got %0d", want.tag, tag);
                    mismatches++;
                end
                if (payload !== want.payload)
                begin
                    $error("payload: expected %0h, got %0h", want.payload, payload);
                    mismatches++;
                end
                if (run_step !== want.run_step)
                begin
                    $error("run_step: expected %0d, got %0d", want.run_step, run_step);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // output stall: random, or a long hold-off when requested
    always @(posedge clk)
    begin : stall_driver
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // runs from the zero state, empty flushes and the unused operation
    task automatic test_run_start();
        send_item(OP_APPEND, 32'h0);
        send_item(OP_APPEND, 32'h0);
        send_item(OP_FLUSH, 32'hFFFF_FFFF);
        send_item(OP_FLUSH, 32'h0);
        send_item(OP_IGNORE, 32'hFFFF_FFFF);
        send_item(OP_CHECKPOINT, 32'h0);
        send_item(OP_APPEND, 32'd7);
        send_item(OP_APPEND, 32'd14);
        send_item(OP_APPEND, 32'd21);
        send_item(OP_APPEND, 32'd28);
        send_item(OP_FLUSH, 32'h0);
    endtask

    // wraparound differences, the most negative step and delta against absolute
    task automatic test_extremes();
        send_item(OP_APPEND, 32'hFFFF_FFFF);
        send_item(OP_APPEND, 32'h0);
        send_item(OP_APPEND, 32'h8000_0000);
        send_item(OP_APPEND, 32'h0);
        send_item(OP_APPEND, 32'h8000_0000);
        // checkpoint closing a run gives two tokens
        send_item(OP_CHECKPOINT, 32'h7FFF_FFFF);
        send_item(OP_APPEND, 32'h7FFF_FFFF);
        send_item(OP_CHECKPOINT, 32'd5);
        send_item(OP_APPEND, 32'd3);
        send_item(OP_APPEND, 32'd100);
        send_item(OP_FLUSH, 32'h0);
        // last id equal to the magnitude gives an absolute id
        send_item(OP_APPEND, 32'd50);
        send_item(OP_APPEND, 32'd10);
        send_item(OP_FLUSH, 32'h0);
    endtask

    function automatic logic [31:0] pick_step();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return 32'($signed($urandom_range(40)) - 20);
        else if (pick < 75)
            return 32'($signed($urandom_range(200000)) - 100000);
        else
            return $urandom;
    endfunction

    // mostly runs of equal steps, with checkpoints, flushes and noise between
    task automatic test_random_mix(input int items);
        int          done;
        int          pick;
        int          len;
        logic [31:0] st;
        done = 0;
        while (done < items)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                st  = pick_step();
                len = $urandom_range(1, 6);
                repeat (len) send_item(OP_APPEND, enc_prev + st);
                done += len;
            end
            else if (pick < 70)
            begin
                send_item(OP_APPEND, ($urandom_range(1)) ? $urandom : $urandom_range(64));
                done++;
            end
            else if (pick < 82)
            begin
                send_item(OP_CHECKPOINT, ($urandom_range(1)) ? $urandom : $urandom_range(64));
                done++;
            end
            else if (pick < 92)
            begin
                send_item(OP_FLUSH, $urandom);
                done++;
            end
            else
                send_item(OP_IGNORE, $urandom);
        end
    endtask

    // receiver holds off while the sender keeps offering token-producing items
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 3 == 2)
                send_item(OP_CHECKPOINT, $urandom);
            else
                send_item(OP_APPEND, enc_prev + 32'(i * 13 + 1));
        end
    endtask

    initial
    begin
        enc_prev  = 32'h0;
        enc_step  = 32'h0;
        enc_count = 64'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 70;
        test_run_start();
        test_extremes();
        test_random_mix(115);
        wait_quiet();

        send_idle_pct = 70;
        recv_idle_pct = 37;
        test_random_mix(115);
        wait_quiet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(115);
        test_backpressure();
        wait_quiet();

        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/dre_pkg.sv
rtl/core/dre_encode.sv
rtl/core/dre_out_queue.sv
rtl/core/delta_run_length_encoder.sv
tb/sv/tb.sv
